// ===== hdl/vma_pkg.sv =====
// Package for the velocity moment accumulator: field widths, register
// indexes, sequencer states and the saturation helpers for the results.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package vma_pkg;

  localparam int SAMPLE_W   = 20;
  localparam int VEL_W      = 12;
  localparam int DIFF_W     = VEL_W + 1;
  localparam int D2_W       = 26;
  localparam int SUM0_W     = 35;
  localparam int SUM1_W     = 47;
  localparam int SUM2_W     = 59;
  localparam int Q16_W      = 16;
  localparam int TEMP_W     = 24;
  localparam int MUL_A_W    = 36;
  localparam int MUL_B_W    = 27;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int DIV_W      = 75;
  localparam int DIV_CNT_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 35;
  localparam int TLO_W      = SUM0_W;
  localparam int THI_W      = SUM2_W - TLO_W;

  localparam logic [VEL_W-1:0]  MEAN_MAX = 12'h7FF;
  localparam logic [VEL_W-1:0]  MEAN_MIN = 12'h800;
  localparam logic [Q16_W-1:0]  Q16_RESET = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_VOL   = 3'd0,
    CFG_TEMP_SCALE  = 3'd1,
    CFG_REF_VX      = 3'd2,
    CFG_REF_VY      = 3'd3,
    CFG_REF_VZ      = 3'd4,
    CFG_DENS_FLOOR  = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DX,
    ST_DY,
    ST_DZ,
    ST_FX,
    ST_FY,
    ST_FZ,
    ST_SEC,
    ST_ACC,
    ST_DENS,
    ST_TLO,
    ST_THI,
    ST_TCOMB,
    ST_DSTART,
    ST_DWAIT,
    ST_EMIT
  } vma_state_t;

  typedef enum logic [1:0] {
    DSEL_X,
    DSEL_Y,
    DSEL_Z,
    DSEL_TEMP
  } div_sel_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Quotient of a magnitude, signed back and clamped to the 12-bit range.
  function automatic logic [VEL_W-1:0] mean_sat(input logic [DIV_W-1:0] q,
                                                input logic neg);
    logic             big_pos;
    logic             big_neg;
    logic [VEL_W-1:0] res;
    big_pos = |q[DIV_W-1:VEL_W-1];
    big_neg = (|q[DIV_W-1:VEL_W]) || (q[VEL_W-1] && (|q[VEL_W-2:0]));
    if (!neg) begin
      res = big_pos ? MEAN_MAX : q[VEL_W-1:0];
    end else begin
      res = big_neg ? MEAN_MIN : (VEL_W'(0) - q[VEL_W-1:0]);
    end
    return res;
  endfunction

  // Drops the Q16 fraction and clamps to the temperature width.
  function automatic logic [TEMP_W-1:0] temp_sat(input logic [DIV_W-1:0] q);
    logic [TEMP_W-1:0] res;
    if (|q[DIV_W-1:TEMP_W+Q16_W]) begin
      res = '1;
    end else begin
      res = q[TEMP_W+Q16_W-1:Q16_W];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/velocity_moment_accumulator.sv =====
// Top level of the velocity moment accumulator: sequencer, accumulators,
// configuration registers and result register. Depends on vma_pkg,
// vma_mul and vma_div.
//
// Usage: samples of one velocity cube arrive as valid/ready transactions on
// the in_ channel, each with its node velocity; in_last_sample marks the
// final node. One shared multiplier builds the squared distances and the
// moments, and in_ready stays low after each transaction until the
// sequencer is back in idle. After the last sample the block forms
// density and the scaled second moment; when the sum exceeds the floor it
// runs four 75-step divisions on one shared divider. Either way it loads
// one transaction on the out_ channel.
// The result sits in an output register; a stalled receiver only holds the
// block when a second result is ready before the first one was taken.
// Configuration is a write port (cfg_we, cfg_index, cfg_wdata); indexes
// past the register list are ignored.
// Synchronous reset loads the register defaults, clears the moment sums
// and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none

module velocity_moment_accumulator
  import vma_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [SAMPLE_W-1:0]     in_sample_value,
  input  wire logic signed [VEL_W-1:0] in_vel_x,
  input  wire logic signed [VEL_W-1:0] in_vel_y,
  input  wire logic signed [VEL_W-1:0] in_vel_z,
  input  wire logic                    in_last_sample,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [SUM0_W-1:0]            out_density,
  output logic signed [VEL_W-1:0]      out_mean_vx,
  output logic signed [VEL_W-1:0]      out_mean_vy,
  output logic signed [VEL_W-1:0]      out_mean_vz,
  output logic [TEMP_W-1:0]            out_temperature,
  output logic                         out_above_floor
);

  // Configuration registers.
  logic [Q16_W-1:0]  phase_vol_r;
  logic [Q16_W-1:0]  temp_scale_r;
  logic [VEL_W-1:0]  ref_vx_r, ref_vy_r, ref_vz_r;
  logic [SUM0_W-1:0] floor_r;

  vma_state_t state_r, state_nxt;

  // Captured sample.
  logic [SAMPLE_W-1:0] s_r, s_nxt;
  logic [VEL_W-1:0]    vx_r, vx_nxt, vy_r, vy_nxt, vz_r, vz_nxt;
  logic                last_r, last_nxt;

  // Moment sums.
  logic [SUM0_W-1:0] sum0_r, sum0_nxt;
  logic [SUM1_W-1:0] sumx_r, sumx_nxt, sumy_r, sumy_nxt, sumz_r, sumz_nxt;
  logic [SUM2_W-1:0] sum2_r, sum2_nxt;
  logic [D2_W-1:0]   d2_r, d2_nxt;

  // Results under construction.
  logic [SUM0_W-1:0] dens_res_r, dens_res_nxt;
  logic              above_res_r, above_res_nxt;
  logic [VEL_W-1:0]  mx_res_r, mx_res_nxt, my_res_r, my_res_nxt;
  logic [VEL_W-1:0]  mz_res_r, mz_res_nxt;
  logic [TEMP_W-1:0] temp_res_r, temp_res_nxt;
  logic [TLO_W+Q16_W-1:0] tlo_r, tlo_nxt;
  logic [DIV_W-1:0]  tdiv_r, tdiv_nxt;
  div_sel_t          dsel_r, dsel_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [SUM0_W-1:0] out_dens_r, out_dens_nxt;
  logic [VEL_W-1:0]  out_mx_r, out_mx_nxt, out_my_r, out_my_nxt;
  logic [VEL_W-1:0]  out_mz_r, out_mz_nxt;
  logic [TEMP_W-1:0] out_temp_r, out_temp_nxt;
  logic              out_above_r, out_above_nxt;

  // Shared units.
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic                      div_start;
  logic [DIV_W-1:0]          div_dividend;
  logic [DIV_W-1:0]          div_quo;
  div_stat_t                 div_stat;

  logic signed [DIFF_W-1:0]  dx, dy, dz;
  logic [SUM1_W-1:0]         first_sel;
  logic                      first_neg;
  logic [SUM1_W-1:0]         first_mag;
  logic                      in_fire;

  vma_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  vma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (sum0_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign in_fire = in_valid && in_ready;

  assign dx = $signed({vx_r[VEL_W-1], vx_r}) - $signed({ref_vx_r[VEL_W-1], ref_vx_r});
  assign dy = $signed({vy_r[VEL_W-1], vy_r}) - $signed({ref_vy_r[VEL_W-1], ref_vy_r});
  assign dz = $signed({vz_r[VEL_W-1], vz_r}) - $signed({ref_vz_r[VEL_W-1], ref_vz_r});

  // First moment feeding the divider, taken apart into sign and magnitude.
  always_comb begin
    case (dsel_r)
      DSEL_X:  first_sel = sumx_r;
      DSEL_Y:  first_sel = sumy_r;
      DSEL_Z:  first_sel = sumz_r;
      default: first_sel = sumx_r;
    endcase
  end
  assign first_neg = first_sel[SUM1_W-1];
  assign first_mag = first_neg ? (SUM1_W'(0) - first_sel) : first_sel;
  assign div_dividend = (dsel_r == DSEL_TEMP) ? tdiv_r
                                              : {(DIV_W-SUM1_W)'(0), first_mag};

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    s_nxt         = s_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    vz_nxt        = vz_r;
    last_nxt      = last_r;
    sum0_nxt      = sum0_r;
    sumx_nxt      = sumx_r;
    sumy_nxt      = sumy_r;
    sumz_nxt      = sumz_r;
    sum2_nxt      = sum2_r;
    d2_nxt        = d2_r;
    dens_res_nxt  = dens_res_r;
    above_res_nxt = above_res_r;
    mx_res_nxt    = mx_res_r;
    my_res_nxt    = my_res_r;
    mz_res_nxt    = mz_res_r;
    temp_res_nxt  = temp_res_r;
    tlo_nxt       = tlo_r;
    tdiv_nxt      = tdiv_r;
    dsel_nxt      = dsel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_dens_nxt  = out_dens_r;
    out_mx_nxt    = out_mx_r;
    out_my_nxt    = out_my_r;
    out_mz_nxt    = out_mz_r;
    out_temp_nxt  = out_temp_r;
    out_above_nxt = out_above_r;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          s_nxt     = in_sample_value;
          vx_nxt    = in_vel_x;
          vy_nxt    = in_vel_y;
          vz_nxt    = in_vel_z;
          last_nxt  = in_last_sample;
          state_nxt = ST_DX;
        end
      end
      ST_DX: begin
        mul_en    = 1'b1;
        mul_a     = {{(MUL_A_W-DIFF_W){dx[DIFF_W-1]}}, dx};
        mul_b     = {{(MUL_B_W-DIFF_W){dx[DIFF_W-1]}}, dx};
        state_nxt = ST_DY;
      end
      ST_DY: begin
        mul_en    = 1'b1;
        mul_a     = {{(MUL_A_W-DIFF_W){dy[DIFF_W-1]}}, dy};
        mul_b     = {{(MUL_B_W-DIFF_W){dy[DIFF_W-1]}}, dy};
        d2_nxt    = mul_p[D2_W-1:0];
        state_nxt = ST_DZ;
      end
      ST_DZ: begin
        mul_en    = 1'b1;
        mul_a     = {{(MUL_A_W-DIFF_W){dz[DIFF_W-1]}}, dz};
        mul_b     = {{(MUL_B_W-DIFF_W){dz[DIFF_W-1]}}, dz};
        d2_nxt    = d2_r + mul_p[D2_W-1:0];
        state_nxt = ST_FX;
      end
      ST_FX: begin
        mul_en    = 1'b1;
        mul_a     = {(MUL_A_W-SAMPLE_W)'(0), s_r};
        mul_b     = {{(MUL_B_W-VEL_W){vx_r[VEL_W-1]}}, vx_r};
        d2_nxt    = d2_r + mul_p[D2_W-1:0];
        state_nxt = ST_FY;
      end
      ST_FY: begin
        mul_en    = 1'b1;
        mul_a     = {(MUL_A_W-SAMPLE_W)'(0), s_r};
        mul_b     = {{(MUL_B_W-VEL_W){vy_r[VEL_W-1]}}, vy_r};
        sumx_nxt  = sumx_r + mul_p[SUM1_W-1:0];
        state_nxt = ST_FZ;
      end
      ST_FZ: begin
        mul_en    = 1'b1;
        mul_a     = {(MUL_A_W-SAMPLE_W)'(0), s_r};
        mul_b     = {{(MUL_B_W-VEL_W){vz_r[VEL_W-1]}}, vz_r};
        sumy_nxt  = sumy_r + mul_p[SUM1_W-1:0];
        state_nxt = ST_SEC;
      end
      ST_SEC: begin
        mul_en    = 1'b1;
        mul_a     = {(MUL_A_W-SAMPLE_W)'(0), s_r};
        mul_b     = {(MUL_B_W-D2_W)'(0), d2_r};
        sumz_nxt  = sumz_r + mul_p[SUM1_W-1:0];
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        sum2_nxt  = sum2_r + {(SUM2_W-SAMPLE_W-D2_W)'(0), mul_p[SAMPLE_W+D2_W-1:0]};
        sum0_nxt  = sum0_r + {(SUM0_W-SAMPLE_W)'(0), s_r};
        state_nxt = last_r ? ST_DENS : ST_IDLE;
      end
      ST_DENS: begin
        mul_en        = 1'b1;
        mul_a         = {(MUL_A_W-SUM0_W)'(0), sum0_r};
        mul_b         = {(MUL_B_W-Q16_W)'(0), phase_vol_r};
        above_res_nxt = (sum0_r > floor_r);
        state_nxt     = ST_TLO;
      end
      ST_TLO: begin
        mul_en       = 1'b1;
        mul_a        = {(MUL_A_W-TLO_W)'(0), sum2_r[TLO_W-1:0]};
        mul_b        = {(MUL_B_W-Q16_W)'(0), temp_scale_r};
        dens_res_nxt = mul_p[SUM0_W+Q16_W-1:Q16_W];
        state_nxt    = ST_THI;
      end
      ST_THI: begin
        mul_en    = 1'b1;
        mul_a     = {(MUL_A_W-THI_W)'(0), sum2_r[SUM2_W-1:TLO_W]};
        mul_b     = {(MUL_B_W-Q16_W)'(0), temp_scale_r};
        tlo_nxt   = mul_p[TLO_W+Q16_W-1:0];
        state_nxt = ST_TCOMB;
      end
      ST_TCOMB: begin
        // Scale times the full second moment, rebuilt from its two halves.
        tdiv_nxt = {mul_p[THI_W+Q16_W-1:0], TLO_W'(0)}
                 + {(DIV_W-TLO_W-Q16_W)'(0), tlo_r};
        dsel_nxt = DSEL_X;
        if (above_res_r) begin
          state_nxt = ST_DSTART;
        end else begin
          mx_res_nxt   = '0;
          my_res_nxt   = '0;
          mz_res_nxt   = '0;
          temp_res_nxt = '0;
          state_nxt    = ST_EMIT;
        end
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_stat.done) begin
          case (dsel_r)
            DSEL_X:    mx_res_nxt   = mean_sat(div_quo, first_neg);
            DSEL_Y:    my_res_nxt   = mean_sat(div_quo, first_neg);
            DSEL_Z:    mz_res_nxt   = mean_sat(div_quo, first_neg);
            DSEL_TEMP: temp_res_nxt = temp_sat(div_quo);
            default:   temp_res_nxt = temp_res_r;
          endcase
          if (dsel_r == DSEL_TEMP) begin
            state_nxt = ST_EMIT;
          end else begin
            dsel_nxt  = div_sel_t'(dsel_r + 2'd1);
            state_nxt = ST_DSTART;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_dens_nxt  = dens_res_r;
          out_mx_nxt    = mx_res_r;
          out_my_nxt    = my_res_r;
          out_mz_nxt    = mz_res_r;
          out_temp_nxt  = temp_res_r;
          out_above_nxt = above_res_r;
          sum0_nxt      = '0;
          sumx_nxt      = '0;
          sumy_nxt      = '0;
          sumz_nxt      = '0;
          sum2_nxt      = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state, configuration and moment sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      sum0_r       <= '0;
      sumx_r       <= '0;
      sumy_r       <= '0;
      sumz_r       <= '0;
      sum2_r       <= '0;
      dsel_r       <= DSEL_X;
      phase_vol_r  <= Q16_RESET;
      temp_scale_r <= Q16_RESET;
      ref_vx_r     <= '0;
      ref_vy_r     <= '0;
      ref_vz_r     <= '0;
      floor_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sum0_r      <= sum0_nxt;
      sumx_r      <= sumx_nxt;
      sumy_r      <= sumy_nxt;
      sumz_r      <= sumz_nxt;
      sum2_r      <= sum2_nxt;
      dsel_r      <= dsel_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PHASE_VOL:  phase_vol_r  <= cfg_wdata[Q16_W-1:0];
          CFG_TEMP_SCALE: temp_scale_r <= cfg_wdata[Q16_W-1:0];
          CFG_REF_VX:     ref_vx_r     <= cfg_wdata[VEL_W-1:0];
          CFG_REF_VY:     ref_vy_r     <= cfg_wdata[VEL_W-1:0];
          CFG_REF_VZ:     ref_vz_r     <= cfg_wdata[VEL_W-1:0];
          CFG_DENS_FLOOR: floor_r      <= cfg_wdata[SUM0_W-1:0];
          default:        floor_r      <= floor_r;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s_r         <= s_nxt;
    vx_r        <= vx_nxt;
    vy_r        <= vy_nxt;
    vz_r        <= vz_nxt;
    last_r      <= last_nxt;
    d2_r        <= d2_nxt;
    dens_res_r  <= dens_res_nxt;
    above_res_r <= above_res_nxt;
    mx_res_r    <= mx_res_nxt;
    my_res_r    <= my_res_nxt;
    mz_res_r    <= mz_res_nxt;
    temp_res_r  <= temp_res_nxt;
    tlo_r       <= tlo_nxt;
    tdiv_r      <= tdiv_nxt;
    out_dens_r  <= out_dens_nxt;
    out_mx_r    <= out_mx_nxt;
    out_my_r    <= out_my_nxt;
    out_mz_r    <= out_mz_nxt;
    out_temp_r  <= out_temp_nxt;
    out_above_r <= out_above_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_density     = out_dens_r;
  assign out_mean_vx     = $signed(out_mx_r);
  assign out_mean_vy     = $signed(out_my_r);
  assign out_mean_vz     = $signed(out_mz_r);
  assign out_temperature = out_temp_r;
  assign out_above_floor = out_above_r;

`ifndef NO_ASSERTIONS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_DX))
    else $error("accepted transaction did not start the sample sequence");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result appeared outside the emit step");

  a_below_floor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_above_r) |->
      (out_temp_r == '0 && out_mx_r == '0 && out_my_r == '0 && out_mz_r == '0))
    else $error("mean or temperature nonzero below the density floor");
`endif

endmodule

`default_nettype wire

// ===== hdl/vma_mul.sv =====
// Shared signed multiplier of the velocity moment accumulator, one product
// per cycle with a registered result. Depends on vma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vma_mul
  import vma_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic signed [MUL_A_W-1:0] op_a,
  input  wire logic signed [MUL_B_W-1:0] op_b,
  output logic signed [MUL_P_W-1:0]      prod
);

  logic signed [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ===== hdl/vma_div.sv =====
// Restoring divider of the velocity moment accumulator: one quotient bit
// per cycle over a 75-bit dividend and a 35-bit divisor. Depends on vma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vma_div
  import vma_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIV_W-1:0]      dividend,
  input  wire logic [SUM0_W-1:0]     divisor,
  output logic [DIV_W-1:0]           quotient,
  output div_stat_t                  stat
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM0_W-1:0]    rem_r, rem_nxt;
  logic [SUM0_W-1:0]    dvs_r, dvs_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [SUM0_W:0]      trial;
  logic [SUM0_W:0]      diff;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and try it.
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[SUM0_W-1:0] : trial[SUM0_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> done_r)
    else $error("divider left busy without done");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && $past(busy_r)) |-> (rem_r < dvs_r))
    else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

// ===== dv/vma_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for velocity_moment_accumulator. It watches the config port and both
// channels, predicts the moments of every cube and compares each result transaction.
// Depends on vma_pkg for widths, register indexes and saturation constants.

module vma_checker
  import vma_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [SAMPLE_W-1:0]     in_sample_value,
  input  logic signed [VEL_W-1:0] in_vel_x,
  input  logic signed [VEL_W-1:0] in_vel_y,
  input  logic signed [VEL_W-1:0] in_vel_z,
  input  logic                    in_last_sample,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [SUM0_W-1:0]       out_density,
  input  logic signed [VEL_W-1:0] out_mean_vx,
  input  logic signed [VEL_W-1:0] out_mean_vy,
  input  logic signed [VEL_W-1:0] out_mean_vz,
  input  logic [TEMP_W-1:0]       out_temperature,
  input  logic                    out_above_floor,
  output int                      mismatch_count,
  output int                      results_owed
);

  // Quotients at or above 2 to this power saturate the temperature unless the scale is zero.
  localparam int QUOT_SAT_W = 44;

  typedef struct packed {
    logic [SUM0_W-1:0] density;
    logic [VEL_W-1:0]  mean_vx;
    logic [VEL_W-1:0]  mean_vy;
    logic [VEL_W-1:0]  mean_vz;
    logic [TEMP_W-1:0] temperature;
    logic              above_floor;
  } moment_result_t;

  moment_result_t          owed_moments[$];
  moment_result_t          oldest;

  logic [Q16_W-1:0]        phase_vol;
  logic [Q16_W-1:0]        temp_scale;
  logic signed [VEL_W-1:0] mean_ref_x;
  logic signed [VEL_W-1:0] mean_ref_y;
  logic signed [VEL_W-1:0] mean_ref_z;
  logic [SUM0_W-1:0]       floor_level;

  logic [SUM0_W-1:0]       sum0;
  logic [SUM1_W-1:0]       sum1_x;
  logic [SUM1_W-1:0]       sum1_y;
  logic [SUM1_W-1:0]       sum1_z;
  logic [SUM2_W-1:0]       sum2;

  task automatic clear_sums();
    sum0   = '0;
    sum1_x = '0;
    sum1_y = '0;
    sum1_z = '0;
    sum2   = '0;
  endtask

  task automatic accumulate_sample(input logic [SAMPLE_W-1:0] s,
                                   input logic signed [VEL_W-1:0] vx,
                                   input logic signed [VEL_W-1:0] vy,
                                   input logic signed [VEL_W-1:0] vz);
    longint dx;
    longint dy;
    longint dz;
    longint dist2;
    dx    = longint'(vx) - longint'(mean_ref_x);
    dy    = longint'(vy) - longint'(mean_ref_y);
    dz    = longint'(vz) - longint'(mean_ref_z);
    dist2 = dx * dx + dy * dy + dz * dz;
    // Every sum wraps at its own width, exactly as the hardware registers do.
    sum0   = sum0 + SUM0_W'(s);
    sum1_x = sum1_x + SUM1_W'(longint'(s) * longint'(vx));
    sum1_y = sum1_y + SUM1_W'(longint'(s) * longint'(vy));
    sum1_z = sum1_z + SUM1_W'(longint'(s) * longint'(vz));
    sum2   = sum2 + SUM2_W'(longint'(s) * dist2);
  endtask

  // Signed first moment over the sample sum, truncated toward zero and clamped.
  function automatic logic [VEL_W-1:0] mean_ratio(input logic [SUM1_W-1:0] moment);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] quot;
    neg  = moment[SUM1_W-1];
    mag  = neg ? ((64'(1) << SUM1_W) - 64'(moment)) : 64'(moment);
    quot = mag / 64'(sum0);
    if (!neg) begin
      return (quot > 64'(MEAN_MAX)) ? MEAN_MAX : quot[VEL_W-1:0];
    end
    return (quot > 64'(MEAN_MAX) + 1) ? MEAN_MIN : VEL_W'(0) - quot[VEL_W-1:0];
  endfunction

  function automatic logic [TEMP_W-1:0] temperature_ratio();
    logic [63:0] quot;
    logic [63:0] rem;
    logic [63:0] scaled;
    if (temp_scale == '0) begin
      return '0;
    end
    quot = 64'(sum2) / 64'(sum0);
    rem  = 64'(sum2) % 64'(sum0);
    if (quot >= (64'(1) << QUOT_SAT_W)) begin
      return '1;
    end
    scaled = 64'(temp_scale) * quot + (64'(temp_scale) * rem) / 64'(sum0);
    scaled = scaled >> Q16_W;
    return (scaled > 64'({TEMP_W{1'b1}})) ? '1 : scaled[TEMP_W-1:0];
  endfunction

  function automatic moment_result_t cube_moments();
    moment_result_t res;
    logic [63:0]    dens_prod;
    res         = '0;
    dens_prod   = 64'(sum0) * 64'(phase_vol);
    res.density = SUM0_W'(dens_prod >> Q16_W);
    if (sum0 > floor_level) begin
      res.mean_vx     = mean_ratio(sum1_x);
      res.mean_vy     = mean_ratio(sum1_y);
      res.mean_vz     = mean_ratio(sum1_z);
      res.temperature = temperature_ratio();
      res.above_floor = 1'b1;
    end
    return res;
  endfunction

  task automatic check_field(input string tag, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase_vol   = Q16_RESET;
      temp_scale  = Q16_RESET;
      mean_ref_x  = '0;
      mean_ref_y  = '0;
      mean_ref_z  = '0;
      floor_level = '0;
      clear_sums();
      owed_moments.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PHASE_VOL:  phase_vol   = cfg_wdata[Q16_W-1:0];
          CFG_TEMP_SCALE: temp_scale  = cfg_wdata[Q16_W-1:0];
          CFG_REF_VX:     mean_ref_x  = cfg_wdata[VEL_W-1:0];
          CFG_REF_VY:     mean_ref_y  = cfg_wdata[VEL_W-1:0];
          CFG_REF_VZ:     mean_ref_z  = cfg_wdata[VEL_W-1:0];
          CFG_DENS_FLOOR: floor_level = cfg_wdata[SUM0_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_moments.size() == 0) begin
          mismatch_count++;
          $display("%0t: result transaction with none expected, actual density %h",
                   $time, out_density);
        end else begin
          oldest = owed_moments.pop_front();
          check_field("density", 64'(oldest.density), 64'(out_density));
          check_field("mean_vx", 64'(oldest.mean_vx), 64'(unsigned'(out_mean_vx)));
          check_field("mean_vy", 64'(oldest.mean_vy), 64'(unsigned'(out_mean_vy)));
          check_field("mean_vz", 64'(oldest.mean_vz), 64'(unsigned'(out_mean_vz)));
          check_field("temperature", 64'(oldest.temperature), 64'(out_temperature));
          check_field("above_floor", 64'(oldest.above_floor), 64'(out_above_floor));
        end
      end
      if (in_valid && in_ready) begin
        accumulate_sample(in_sample_value, in_vel_x, in_vel_y, in_vel_z);
        if (in_last_sample) begin
          owed_moments.insert(owed_moments.size(), cube_moments());
          clear_sums();
        end
      end
    end
    results_owed = owed_moments.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the velocity_moment_accumulator testbench: clock, reset, stimulus and verdict.
// Depends on vma_pkg, the block itself and vma_checker, which does all prediction.

module testbench
  import vma_pkg::*;
();

  localparam int CYCLE_LIMIT     = 4_000_000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int DRAIN_CYCLES    = 400;
  localparam int ITEMS_PER_PHASE = 288;
  localparam int PHASE_COUNT     = 4;
  localparam int CUBES_PER_SETUP = 8;

  typedef enum int {
    SET_DEFAULT,
    SET_ZERO_SCALE,
    SET_RANDOM,
    SET_EXTREME_REF,
    SET_FLOOR_MAX,
    SET_FLOOR_WIDE
  } setting_kind_t;

  logic                    clk             = 1'b0;
  logic                    rst_n           = 1'b0;
  logic                    cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index       = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata       = '0;
  logic                    in_valid        = 1'b0;
  logic [SAMPLE_W-1:0]     in_sample_value = '0;
  logic signed [VEL_W-1:0] in_vel_x        = '0;
  logic signed [VEL_W-1:0] in_vel_y        = '0;
  logic signed [VEL_W-1:0] in_vel_z        = '0;
  logic                    in_last_sample  = 1'b0;
  logic                    out_ready       = 1'b0;

  logic                    in_ready;
  logic                    out_valid;
  logic [SUM0_W-1:0]       out_density;
  logic signed [VEL_W-1:0] out_mean_vx;
  logic signed [VEL_W-1:0] out_mean_vy;
  logic signed [VEL_W-1:0] out_mean_vz;
  logic [TEMP_W-1:0]       out_temperature;
  logic                    out_above_floor;

  int mismatch_count;
  int results_owed;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int cycle_count    = 0;

  velocity_moment_accumulator u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_value (in_sample_value),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .in_vel_z        (in_vel_z),
    .in_last_sample  (in_last_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_density     (out_density),
    .out_mean_vx     (out_mean_vx),
    .out_mean_vy     (out_mean_vy),
    .out_mean_vz     (out_mean_vz),
    .out_temperature (out_temperature),
    .out_above_floor (out_above_floor)
  );

  vma_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_value (in_sample_value),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .in_vel_z        (in_vel_z),
    .in_last_sample  (in_last_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_density     (out_density),
    .out_mean_vx     (out_mean_vx),
    .out_mean_vy     (out_mean_vy),
    .out_mean_vz     (out_mean_vz),
    .out_temperature (out_temperature),
    .out_above_floor (out_above_floor),
    .mismatch_count  (mismatch_count),
    .results_owed    (results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("velocity_moment_accumulator verification failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [VEL_W-1:0] vx,
                             input logic [VEL_W-1:0] vy, input logic [VEL_W-1:0] vz,
                             input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= s;
    in_vel_x        <= vx;
    in_vel_y        <= vy;
    in_vel_z        <= vz;
    in_last_sample  <= last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) begin
      @(negedge clk);
    end
  endtask

  // Registers change only once the block has gone quiet.
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_setting(input setting_kind_t kind);
    logic [Q16_W-1:0]      pv;
    logic [Q16_W-1:0]      ts;
    logic [VEL_W-1:0]      mx;
    logic [VEL_W-1:0]      my;
    logic [VEL_W-1:0]      mz;
    logic [CFG_DATA_W-1:0] fl;
    pv = Q16_W'($urandom);
    ts = Q16_W'($urandom);
    mx = VEL_W'($urandom);
    my = VEL_W'($urandom);
    mz = VEL_W'($urandom);
    fl = CFG_DATA_W'($urandom_range(0, 1 << 23));
    case (kind)
      SET_DEFAULT: begin
        pv = Q16_RESET;
        ts = Q16_RESET;
        mx = '0;
        my = '0;
        mz = '0;
        fl = '0;
      end
      SET_ZERO_SCALE: begin
        pv = '0;
        ts = '0;
        fl = '0;
      end
      SET_EXTREME_REF: begin
        mx = $urandom_range(0, 1) ? MEAN_MAX : MEAN_MIN;
        my = $urandom_range(0, 1) ? MEAN_MAX : MEAN_MIN;
        mz = $urandom_range(0, 1) ? MEAN_MAX : MEAN_MIN;
        ts = Q16_RESET;
        fl = '0;
      end
      SET_FLOOR_MAX:  fl = '1;
      SET_FLOOR_WIDE: fl = CFG_DATA_W'({$urandom, $urandom});
      default: ;
    endcase
    settle();
    write_reg(CFG_PHASE_VOL, CFG_DATA_W'(pv));
    write_reg(CFG_TEMP_SCALE, CFG_DATA_W'(ts));
    write_reg(CFG_REF_VX, CFG_DATA_W'(mx));
    write_reg(CFG_REF_VY, CFG_DATA_W'(my));
    write_reg(CFG_REF_VZ, CFG_DATA_W'(mz));
    write_reg(CFG_DENS_FLOOR, fl);
    // Indexes past the register list must leave everything untouched.
    for (int k = int'(CFG_DENS_FLOOR) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'({$urandom, $urandom}));
    end
  endtask

  function automatic setting_kind_t pick_setting();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return SET_DEFAULT;
    if (r == 1) return SET_ZERO_SCALE;
    if (r < 6) return SET_RANDOM;
    if (r < 8) return SET_EXTREME_REF;
    if (r == 8) return SET_FLOOR_MAX;
    return SET_FLOOR_WIDE;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(0, 255));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [VEL_W-1:0] pick_velocity();
    case ($urandom_range(0, 9))
      0:       return MEAN_MIN;
      1:       return MEAN_MAX;
      2:       return '0;
      default: return VEL_W'($urandom);
    endcase
  endfunction

  task automatic send_cube();
    int r;
    int size;
    bit all_zero;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      size = $urandom_range(1, 6);
    end else if (r < 95) begin
      size = $urandom_range(7, 30);
    end else begin
      size = $urandom_range(40, 100);
    end
    all_zero = ($urandom_range(0, 19) == 0);
    for (int k = 0; k < size; k++) begin
      send_sample(all_zero ? '0 : pick_sample(), pick_velocity(), pick_velocity(),
                  pick_velocity(), k == size - 1);
    end
  endtask

  task automatic run_directed();
    send_sample('1, MEAN_MAX, MEAN_MAX, MEAN_MAX, 1'b1);
    send_sample('1, MEAN_MIN, MEAN_MIN, MEAN_MIN, 1'b1);
    // A cube whose samples are all zero never clears a zero floor.
    send_sample('0, VEL_W'(37), VEL_W'(-9), MEAN_MAX, 1'b1);
    send_sample(SAMPLE_W'(1), VEL_W'(100), VEL_W'(-5), VEL_W'(7), 1'b0);
    send_sample('1, MEAN_MIN, MEAN_MAX, '0, 1'b0);
    send_sample(SAMPLE_W'(12345), VEL_W'(3), VEL_W'(-3), VEL_W'(1), 1'b1);

    // Reference means opposite the node velocity drive the temperature into saturation.
    settle();
    write_reg(CFG_REF_VX, CFG_DATA_W'(MEAN_MAX));
    write_reg(CFG_REF_VY, CFG_DATA_W'(MEAN_MAX));
    write_reg(CFG_REF_VZ, CFG_DATA_W'(MEAN_MAX));
    send_sample('1, MEAN_MIN, MEAN_MIN, MEAN_MIN, 1'b1);
    settle();
    write_reg(CFG_REF_VX, CFG_DATA_W'(MEAN_MIN));
    write_reg(CFG_REF_VY, CFG_DATA_W'(MEAN_MIN));
    write_reg(CFG_REF_VZ, CFG_DATA_W'(MEAN_MIN));
    send_sample(SAMPLE_W'(1), MEAN_MAX, MEAN_MAX, MEAN_MAX, 1'b1);

    settle();
    write_reg(CFG_REF_VX, '0);
    write_reg(CFG_REF_VY, '0);
    write_reg(CFG_REF_VZ, '0);
    write_reg(CFG_DENS_FLOOR, '1);
    send_sample('1, VEL_W'(500), VEL_W'(-600), VEL_W'(700), 1'b0);
    send_sample('1, VEL_W'(-1), VEL_W'(2), VEL_W'(-3), 1'b1);

    // A sum equal to the floor does not exceed it; one more does.
    settle();
    write_reg(CFG_DENS_FLOOR, CFG_DATA_W'(1000));
    send_sample(SAMPLE_W'(1000), VEL_W'(11), VEL_W'(-22), VEL_W'(33), 1'b1);
    send_sample(SAMPLE_W'(1001), VEL_W'(11), VEL_W'(-22), VEL_W'(33), 1'b1);

    settle();
    write_reg(CFG_DENS_FLOOR, '0);
    write_reg(CFG_PHASE_VOL, '0);
    write_reg(CFG_TEMP_SCALE, '0);
    send_sample('1, VEL_W'(5), VEL_W'(6), VEL_W'(7), 1'b1);
  endtask

  initial begin
    int phase_start;
    int cubes;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 87;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 87;
        end
        default: begin
          send_idle_pct  = 33;
          recv_stall_pct = 33;
        end
      endcase
      phase_start = items_sent;
      cubes       = 0;
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        if (cubes % CUBES_PER_SETUP == 0) begin
          program_setting(pick_setting());
        end
        // Now and then hold the stream until every result has come back.
        if (cubes == 2 || $urandom_range(0, 19) == 0) begin
          wait_drained();
        end
        send_cube();
        cubes++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("velocity_moment_accumulator verification clean");
    end else begin
      $display("velocity_moment_accumulator verification failed");
    end
    $finish;
  end

endmodule
